>>> hdl/nvra_pkg.sv
// constants, types and helpers for the nearest volume resample address core
// no dependencies
`default_nettype none

package nvra_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int DIM_W     = 13;
  localparam int COORD_W   = 12;
  localparam int IDX_W     = 36;
  localparam int NUM_W     = 2 * DIM_W;
  localparam int DEN_W     = DIM_W + 1;
  localparam int QUO_W     = COORD_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int CFG_IDX_W = 3;
  localparam int IN_W      = 40;
  localparam int OUT_W     = 2 * IDX_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_DEPTH      = 3'd0,
    REG_SRC_WIDTH      = 3'd1,
    REG_SRC_HEIGHT     = 3'd2,
    REG_DST_DEPTH      = 3'd3,
    REG_DST_WIDTH      = 3'd4,
    REG_DST_HEIGHT     = 3'd5,
    REG_SLICE_ZERO_TOP = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic             err;
    logic [IDX_W-1:0] dst;
  } side_t;

  // size register as used: zero acts as one, oversize clamps
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/nvra_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on nvra_pkg; quotient known to fit in QUO_W bits
`default_nettype none

module nvra_div (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [nvra_pkg::NUM_W-1:0] num,
  input  wire logic [nvra_pkg::DEN_W-1:0] den,
  output logic      [nvra_pkg::QUO_W-1:0] quo
);
  import nvra_pkg::*;

  logic [DEN_W-1:0] rem [DIV_STEPS];
  logic [QUO_W-1:0] low [DIV_STEPS];
  logic [QUO_W-1:0] qb  [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [QUO_W-1:0] q_in;
    logic [DEN_W:0]   trial;
    logic             take;

    if (j == 0) begin : g_first
      assign rem_in = num[NUM_W-1:QUO_W];
      assign low_in = num[QUO_W-1:0];
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem[j-1];
      assign low_in = low[j-1];
      assign q_in   = qb[j-1];
    end

    assign trial = {rem_in, low_in[QUO_W-1]};
    assign take  = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= take ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        low[j] <= {low_in[QUO_W-2:0], 1'b0};
        qb[j]  <= {q_in[QUO_W-2:0], take};
      end
    end
  end

  assign quo = qb[DIV_STEPS-1];

endmodule

`default_nettype wire

>>> hdl/nearest_volume_resample_address_core.sv
// Nearest-neighbour 3D resampling address core. One target voxel coordinate per item in,
// one source and one target flat index per item out. Fully pipelined: a new item can be
// accepted every clock while the output is not stalled; a result passes sixteen register
// stages: input, setup, the twelve one-bit-per-stage divider stages and two multiply-add
// stages. A stalled output stalls the whole pipeline. Configuration writes
// take effect at once and must only be issued while no items are in flight.
// Depends on nvra_pkg and nvra_div.
`default_nettype none

module nearest_volume_resample_address_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [nvra_pkg::IN_W-1:0]      s_axis_tdata,  // tgt_d, tgt_w, tgt_h, pad
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [nvra_pkg::OUT_W-1:0]     m_axis_tdata,  // src_index, dst_index
  output logic                                m_axis_tuser,  // coord_error
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [nvra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [nvra_pkg::DIM_W-1:0]     cfg_data
);
  import nvra_pkg::*;

  logic [DIM_W-1:0] sd_n, sw_n, sh_n, dd_n, dw_n, dh_n;
  logic             slice_zero_top;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_n <= DIM_W'(1);
      sw_n <= DIM_W'(1);
      sh_n <= DIM_W'(1);
      dd_n <= DIM_W'(1);
      dw_n <= DIM_W'(1);
      dh_n <= DIM_W'(1);
      slice_zero_top <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SRC_DEPTH:      sd_n <= eff_dim(cfg_data);
        REG_SRC_WIDTH:      sw_n <= eff_dim(cfg_data);
        REG_SRC_HEIGHT:     sh_n <= eff_dim(cfg_data);
        REG_DST_DEPTH:      dd_n <= eff_dim(cfg_data);
        REG_DST_WIDTH:      dw_n <= eff_dim(cfg_data);
        REG_DST_HEIGHT:     dh_n <= eff_dim(cfg_data);
        REG_SLICE_ZERO_TOP: slice_zero_top <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: input capture
  logic               v1;
  logic [COORD_W-1:0] td1, tw1, th1;

  // stage 2: range check, numerators, partial target index
  logic               v2;
  logic               err2;
  logic [NUM_W-1:0]   nd2, nw2, nh2;
  logic [23:0]        dp2;
  logic [COORD_W-1:0] th2;

  // divider stages
  logic               vd [DIV_STEPS];
  side_t              sd [DIV_STEPS];
  logic [QUO_W-1:0]   qd, qw, qh;

  // stage after divider
  logic               v15;
  side_t              s15;
  logic [23:0]        a15;
  logic [QUO_W-1:0]   sh15;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v15 <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < DIV_STEPS; i++) begin
        vd[i] <= 1'b0;
      end
    end else if (en) begin
      v1  <= s_axis_tvalid;
      v2  <= v1;
      vd[0] <= v2;
      for (int i = 1; i < DIV_STEPS; i++) begin
        vd[i] <= vd[i-1];
      end
      v15 <= vd[DIV_STEPS-1];
      m_axis_tvalid <= v15;
    end
  end

  logic [QUO_W-1:0] sdm;
  assign sdm = slice_zero_top ? qd : QUO_W'(sd_n - DIM_W'(1) - {1'b0, qd});

  always_ff @(posedge clk) begin
    if (en) begin
      td1 <= s_axis_tdata[11:0];
      tw1 <= s_axis_tdata[23:12];
      th1 <= s_axis_tdata[35:24];

      err2 <= ({1'b0, td1} >= dd_n) || ({1'b0, tw1} >= dw_n) || ({1'b0, th1} >= dh_n);
      nd2  <= NUM_W'({td1, 1'b1} * sd_n);
      nw2  <= NUM_W'({tw1, 1'b1} * sw_n);
      nh2  <= NUM_W'({th1, 1'b1} * sh_n);
      dp2  <= 24'(td1 * dw_n + tw1);
      th2  <= th1;

      sd[0].err <= err2;
      sd[0].dst <= IDX_W'(dp2 * dh_n + th2);
      for (int i = 1; i < DIV_STEPS; i++) begin
        sd[i] <= sd[i-1];
      end

      s15  <= sd[DIV_STEPS-1];
      a15  <= 24'(sdm * sw_n + qw);
      sh15 <= qh;

      m_axis_tuser <= s15.err;
      if (s15.err) begin
        m_axis_tdata <= '0;
      end else begin
        m_axis_tdata[IDX_W-1:0]     <= IDX_W'(a15 * sh_n + sh15);
        m_axis_tdata[OUT_W-1:IDX_W] <= s15.dst;
      end
    end
  end

  nvra_div u_div_d (.clk(clk), .en(en), .num(nd2), .den({dd_n, 1'b0}), .quo(qd));
  nvra_div u_div_w (.clk(clk), .en(en), .num(nw2), .den({dw_n, 1'b0}), .quo(qw));
  nvra_div u_div_h (.clk(clk), .en(en), .num(nh2), .den({dh_n, 1'b0}), .quo(qh));

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("coordinate error with nonzero indices");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |=> $stable(v15) && $stable(v2) && $stable(vd[DIV_STEPS-1]))
    else $error("pipeline moved during stall");

  a_err_flow: assert property (@(posedge clk) disable iff (rst)
    en && v15 |=> m_axis_tuser == $past(s15.err))
    else $error("error flag lost on output");
`endif

endmodule

`default_nettype wire
